// File: design/png_unf_pkg.sv
// shared types and codes for the png scanline unfilter
package png_unf_pkg;

  typedef logic [7:0] byte_t;

  // filter type codes carried in the first byte of each row
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // configuration register indexes and widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 1'd1;

  localparam int PIXEL_BYTES_W = 4;
  localparam int ROW_BYTES_W   = 14;

endpackage

// File: design/png_unf_ifs.sv
// stream and configuration channel interfaces for the png scanline unfilter
interface png_unf_in_if;
  logic                valid;
  logic                ready;
  png_unf_pkg::byte_t  stream_byte;
  logic                image_start;

  modport source (output valid, stream_byte, image_start, input ready);
  modport sink   (input valid, stream_byte, image_start, output ready);
endinterface

interface png_unf_out_if;
  logic                valid;
  logic                ready;
  png_unf_pkg::byte_t  pixel_value;
  logic                row_last;
  logic                bad_filter;

  modport source (output valid, pixel_value, row_last, bad_filter, input ready);
  modport sink   (input valid, pixel_value, row_last, bad_filter, output ready);
endinterface

interface png_unf_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [png_unf_pkg::CFG_IDX_W-1:0]      index;
  logic [png_unf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/png_unf_ram.sv
// generic single-write, single-read ram with registered read data (read-first)
module png_unf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/png_scanline_unfilter_top.sv
// png scanline unfilter: reverses the per-row filters of a decompressed png stream
//
// pix_in takes one stream byte per transfer. The first byte of each row (or any
// byte with image_start set) is the filter type and produces nothing; every
// following byte produces one reconstructed byte on pix_out, with row_last on
// the final byte of the row and bad_filter on every byte of a row whose filter
// type was above four (such a row passes through unchanged).
// cfg writes pixel_bytes (index 0) and row_bytes (index 1); it is always ready
// and should only be written while no result is outstanding.
// The result is valid in the cycle after the input transfer. One byte is taken
// every cycle while pix_out does not stall: the prior row comes from a line
// store read at the next column, and the predictor is short logic into the
// result register. When pix_out stalls the result register holds and pix_in.ready
// drops until the result is taken; ready follows pix_out.ready in the same cycle.
// After reset: pixel_bytes 1, row_bytes 1, next byte is a filter type, the
// next row counts as the first of an image. The line store is not cleared;
// entries are always written before they are read for a fixed row length.
module png_scanline_unfilter_top #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input logic         clk,
  input logic         rst,
  png_unf_in_if.sink  pix_in,
  png_unf_out_if.source pix_out,
  png_unf_cfg_if.sink cfg
);
  import png_unf_pkg::*;

  localparam int AW = MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int SW = MAX_PIXEL_BYTES > 1 ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int CW = 17;

  function automatic byte_t paeth(byte_t a, byte_t b, byte_t c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = da < 0 ? 10'(-da) : 10'(da);
    pb = db < 0 ? 10'(-db) : 10'(db);
    pc = dc < 0 ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  // configuration
  logic [PIXEL_BYTES_W-1:0] pixel_bytes;
  logic [ROW_BYTES_W-1:0]   row_bytes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes <= PIXEL_BYTES_W'(1);
      row_bytes   <= ROW_BYTES_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PIXEL_BYTES: pixel_bytes <= cfg.data[PIXEL_BYTES_W-1:0];
        CFG_ROW_BYTES:   row_bytes   <= cfg.data[ROW_BYTES_W-1:0];
        default:         ;
      endcase
    end
  end

  logic [PIXEL_BYTES_W-1:0] pb_eff;
  logic [CW-1:0]            rb_eff;

  always_comb begin
    if (pixel_bytes == '0) begin
      pb_eff = PIXEL_BYTES_W'(1);
    end else if (pixel_bytes > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
      pb_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
    end else begin
      pb_eff = pixel_bytes;
    end
    if (row_bytes == '0) begin
      rb_eff = CW'(1);
    end else if (CW'(row_bytes) > CW'(MAX_ROW_BYTES)) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CW'(row_bytes);
    end
  end

  // row state
  logic          awaiting;
  logic [AW-1:0] col;
  logic          first_row;
  logic          row_bad;
  filt_t         filt_kind;
  logic [SW-1:0] mod_cnt [MAX_PIXEL_BYTES];   // col mod (k+1) for each k
  byte_t         left_hist [MAX_PIXEL_BYTES];
  byte_t         ul_hist   [MAX_PIXEL_BYTES];

  // result register
  logic  out_valid;
  byte_t out_value;
  logic  out_last;
  logic  out_bad;

  logic          acc;
  logic          is_filter;
  logic          pix_acc;
  logic          last;
  logic          have_left;
  logic [SW-1:0] pb_idx;
  logic [SW-1:0] slot;
  byte_t         ram_rdata;
  byte_t         byp_data;
  logic          byp_valid;
  byte_t         a;
  byte_t         b;
  byte_t         c;
  byte_t         pred;
  byte_t         value;
  logic [8:0]    avg_sum;
  logic [AW-1:0] col_next;

  assign pix_in.ready = !out_valid || pix_out.ready;
  assign acc          = pix_in.valid && pix_in.ready;
  assign is_filter    = awaiting || pix_in.image_start;
  assign pix_acc      = acc && !is_filter;

  assign pb_idx    = SW'(pb_eff - PIXEL_BYTES_W'(1));
  assign slot      = mod_cnt[pb_idx];
  assign last      = (CW'(col) + CW'(1)) >= rb_eff;
  assign have_left = CW'(col) >= CW'(pb_eff);

  always_comb begin
    a       = have_left ? left_hist[slot] : 8'd0;
    b       = first_row ? 8'd0 : (byp_valid ? byp_data : ram_rdata);
    c       = (have_left && !first_row) ? ul_hist[slot] : 8'd0;
    avg_sum = {1'b0, a} + {1'b0, b};
    case (filt_kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    value = pix_in.stream_byte + pred;
  end

  always_comb begin
    col_next = col;
    if (acc) begin
      if (is_filter || last) begin
        col_next = '0;
      end else begin
        col_next = col + AW'(1);
      end
    end
  end

  // line store: read address is the next column, so the read data is ready for the byte that needs it
  png_unf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (pix_acc),
    .waddr (col),
    .wdata (value),
    .raddr (col_next),
    .rdata (ram_rdata)
  );

  // write and read of the same entry in one cycle: forward the new byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= pix_acc && (col == col_next);
    end
    byp_data <= value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting  <= 1'b1;
      col       <= '0;
      first_row <= 1'b1;
      row_bad   <= 1'b0;
      filt_kind <= FILT_NONE;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        mod_cnt[k]   <= '0;
        left_hist[k] <= 8'd0;
        ul_hist[k]   <= 8'd0;
      end
    end else if (acc) begin
      col <= col_next;
      if (is_filter) begin
        awaiting <= 1'b0;
        if (pix_in.image_start) begin
          first_row <= 1'b1;
        end
        if (pix_in.stream_byte > 8'(FILT_PAETH)) begin
          row_bad   <= 1'b1;
          filt_kind <= FILT_NONE;
        end else begin
          row_bad   <= 1'b0;
          filt_kind <= filt_t'(pix_in.stream_byte[2:0]);
        end
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          mod_cnt[k] <= '0;
        end
      end else begin
        left_hist[slot] <= value;
        ul_hist[slot]   <= b;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          mod_cnt[k] <= (mod_cnt[k] == SW'(k)) ? '0 : mod_cnt[k] + SW'(1);
        end
        if (last) begin
          awaiting  <= 1'b1;
          first_row <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_acc) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
    if (pix_acc) begin
      out_value <= value;
      out_last  <= last;
      out_bad   <= row_bad;
    end
  end

  assign pix_out.valid       = out_valid;
  assign pix_out.pixel_value = out_value;
  assign pix_out.row_last    = out_last;
  assign pix_out.bad_filter  = out_bad;

  // a row-ending byte leaves the block waiting for a filter type
  a_row_end_waits: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && last) |=> (awaiting && col == '0))
    else $error("row end did not return to filter type");

  // the selected residue stays below the pixel size
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    CW'(slot) < CW'(pb_eff))
    else $error("pixel slot out of range");

  // within the first pixel the residue equals the column
  a_slot_first_pixel: assert property (@(posedge clk) disable iff (rst)
    (!awaiting && !have_left) |-> (CW'(slot) == CW'(col)))
    else $error("pixel slot disagrees with column");

  // forwarding only follows a store write
  a_bypass_after_write: assert property (@(posedge clk) disable iff (rst)
    byp_valid |-> $past(pix_acc))
    else $error("line store forward without write");

  // a filter byte never produces a result
  a_filter_no_result: assert property (@(posedge clk) disable iff (rst)
    (acc && is_filter && !out_valid) |=> !out_valid)
    else $error("result produced by filter type byte");

endmodule
